// File: src/indexed_list_insert_delete_unit_assert.svh
// ----------------------------------------------------------------------------
// Indexed list unit assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define ILID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ilid assertion failed");

// Check cons in the cycle after ante.
`define ILID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ilid assertion failed");

`endif

// File: src/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared constants, codes and control structs of the indexed list unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ilid_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET      = 3'd0,
		CMD_INS_HEAD = 3'd1,
		CMD_INS_TAIL = 3'd2,
		CMD_INS_AT   = 3'd3,
		CMD_DEL_AT   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Broadcast to every cell of the row.
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] val;
	} cell_ctl_t;

	// Per-command outcome from the controller.
	typedef struct packed {
		status_t          status;
		logic             hit;
		logic [IDX_W-1:0] rd_idx;
		logic [CNT_W-1:0] length;
	} res_t;

endpackage

`default_nettype wire

// File: src/indexed_list_insert_delete_unit.sv
// One command per clock: a command is taken whenever the result register is
// empty or its result is being taken in the same cycle, and its result
// appears in the cycle after the transfer. Inserts and deletes move every
// later element one place at once, since each of the CAPACITY cells loads
// from its neighbor in parallel; get reads the addressed cell through a
// one-hot select over the row. Stored values are not cleared at reset, only
// the element count, and no slot at or past the count is ever returned.
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of signed 32-bit values with get, insert and delete by index.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_insert_delete_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [ilid_pkg::CMD_W-1:0]         cmd,
	input  wire logic [ilid_pkg::CNT_W-1:0]         position,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] value_in,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed [ilid_pkg::DATA_W-1:0]      read_value,
	output logic                                    found,
	output logic [1:0]                              status,
	output logic [ilid_pkg::CNT_W-1:0]              length
);

	logic                                fire;
	ilid_pkg::cell_ctl_t                 ctl;
	ilid_pkg::res_t                      res;
	logic signed [ilid_pkg::DATA_W-1:0]  cell_val [ilid_pkg::CAPACITY];
	logic signed [ilid_pkg::DATA_W-1:0]  rd_val;

	logic                                out_valid_q;
	logic signed [ilid_pkg::DATA_W-1:0]  read_value_q;
	logic                                found_q;
	logic [1:0]                          status_q;
	logic [ilid_pkg::CNT_W-1:0]          length_q;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	ilid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.cmd      (cmd),
		.position (position),
		.value_in (value_in),
		.ctl      (ctl),
		.res      (res)
	);

	// Row of cells; the end cells feed back their own value.
	for (genvar i = 0; i < ilid_pkg::CAPACITY; i++) begin : g_cell
		logic signed [ilid_pkg::DATA_W-1:0] lower;
		logic signed [ilid_pkg::DATA_W-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = cell_val[i];
		end else begin : g_lower
			assign lower = cell_val[i-1];
		end
		if (i == ilid_pkg::CAPACITY - 1) begin : g_last
			assign upper = cell_val[i];
		end else begin : g_upper
			assign upper = cell_val[i+1];
		end
		ilid_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (ilid_pkg::IDX_W'(i)),
			.lower_val (lower),
			.upper_val (upper),
			.val       (cell_val[i])
		);
	end

	// Select the addressed cell.
	always_comb begin
		rd_val = '0;
		for (int i = 0; i < ilid_pkg::CAPACITY; i++) begin
			if (res.rd_idx == ilid_pkg::IDX_W'(i)) rd_val = rd_val | cell_val[i];
		end
	end

	// Hold the result until its transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_value_q <= res.hit ? rd_val : -32'sd1;
			found_q      <= res.hit;
			status_q     <= res.status;
			length_q     <= res.length;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign found      = found_q;
	assign status     = status_q;
	assign length     = length_q;

endmodule

`default_nettype wire

// File: src/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot: load the new value, take the lower neighbor, take the upper
// neighbor, or hold.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_cell (
	input  wire logic                                      clk,
	input  wire ilid_pkg::cell_ctl_t                       ctl,
	input  wire logic [ilid_pkg::IDX_W-1:0]                idx,
	input  wire logic signed [ilid_pkg::DATA_W-1:0]        lower_val,
	input  wire logic signed [ilid_pkg::DATA_W-1:0]        upper_val,
	output logic signed [ilid_pkg::DATA_W-1:0]             val
);

	logic signed [ilid_pkg::DATA_W-1:0] val_q;

	// Load on insert at this slot, shift up on insert below it, down on delete at or below.
	always_ff @(posedge clk) begin
		if (ctl.ins && (idx == ctl.idx)) begin
			val_q <= ctl.val;
		end else if (ctl.ins && (idx > ctl.idx)) begin
			val_q <= lower_val;
		end else if (ctl.del && (idx >= ctl.idx)) begin
			val_q <= upper_val;
		end
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: src/ilid_ctrl.sv
// ----------------------------------------------------------------------------
// ilid_ctrl
// Decode a command against the element count, drive the cell row and keep
// the count.
// ----------------------------------------------------------------------------
`default_nettype none

module ilid_ctrl (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               fire,
	input  wire logic [ilid_pkg::CMD_W-1:0]         cmd,
	input  wire logic [ilid_pkg::CNT_W-1:0]         position,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] value_in,
	output ilid_pkg::cell_ctl_t                     ctl,
	output ilid_pkg::res_t                          res
);

	logic [ilid_pkg::CNT_W-1:0] count_q;
	logic [ilid_pkg::CNT_W-1:0] count_nxt;
	logic                       full;
	logic                       ins;
	logic                       del;
	logic [ilid_pkg::IDX_W-1:0] idx;
	ilid_pkg::status_t          status;
	logic                       hit;

	assign full = (count_q == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY));

	// Classify the command and pick the slot it works on.
	always_comb begin
		ins    = 1'b0;
		del    = 1'b0;
		hit    = 1'b0;
		idx    = position[ilid_pkg::IDX_W-1:0];
		status = ilid_pkg::ST_DONE;
		case (ilid_pkg::cmd_t'(cmd))
			ilid_pkg::CMD_GET: begin
				if (position < count_q) hit = 1'b1;
				else status = ilid_pkg::ST_RANGE;
			end
			ilid_pkg::CMD_INS_HEAD: begin
				idx = '0;
				if (full) status = ilid_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ilid_pkg::CMD_INS_TAIL: begin
				idx = count_q[ilid_pkg::IDX_W-1:0];
				if (full) status = ilid_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ilid_pkg::CMD_INS_AT: begin
				if (position > count_q) status = ilid_pkg::ST_RANGE;
				else if (full) status = ilid_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ilid_pkg::CMD_DEL_AT: begin
				if (position >= count_q) status = ilid_pkg::ST_RANGE;
				else del = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		count_nxt = count_q;
		if (ins) count_nxt = count_q + 1'b1;
		else if (del) count_nxt = count_q - 1'b1;
	end

	// Advance the count on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (fire) begin
			count_q <= count_nxt;
		end
	end

	assign ctl.ins = ins && fire;
	assign ctl.del = del && fire;
	assign ctl.idx = idx;
	assign ctl.val = value_in;

	assign res.status = status;
	assign res.hit    = hit;
	assign res.rd_idx = position[ilid_pkg::IDX_W-1:0];
	assign res.length = count_nxt;

endmodule

`default_nettype wire

// File: src/ilid_checker.sv
// ----------------------------------------------------------------------------
// ilid_checker
// Port-level checks on the result channel of the indexed list unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "indexed_list_insert_delete_unit_assert.svh"

module ilid_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               out_valid,
	input  wire logic                               out_ready,
	input  wire logic signed [ilid_pkg::DATA_W-1:0] read_value,
	input  wire logic                               found,
	input  wire logic [1:0]                         status,
	input  wire logic [ilid_pkg::CNT_W-1:0]         length
);

	// A stalled result stays put.
	`ILID_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(read_value) && $stable(status) && $stable(length))

	// A hit always completes.
	`ILID_ASSERT_NOW(a_hit_done, out_valid && found, status == 2'(ilid_pkg::ST_DONE))

	// A miss returns the all-ones value.
	`ILID_ASSERT_NOW(a_miss_value, out_valid && !found, read_value == -32'sd1)

	// The count never exceeds the capacity.
	`ILID_ASSERT_NOW(a_len_cap, out_valid,
		length <= ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))

	// A refused insert means the list is at capacity.
	`ILID_ASSERT_NOW(a_full_len, out_valid && (status == 2'(ilid_pkg::ST_FULL)),
		length == ilid_pkg::CNT_W'(ilid_pkg::CAPACITY))

endmodule

bind indexed_list_insert_delete_unit ilid_checker u_ilid_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.read_value (read_value),
	.found      (found),
	.status     (status),
	.length     (length)
);

`default_nettype wire

// File: test/indexed_list_insert_delete_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit_tb
// Self-checking bench for the indexed list unit. Commands are driven through
// the input handshake. A local copy of the list predicts each result, and the
// results are compared field by field in arrival order. Directed cases cover
// empty, boundary and full lists. Random traffic alternates between growing
// and shrinking the list, under changing idle patterns and one long output
// stall.
// ----------------------------------------------------------------------------

module indexed_list_insert_delete_unit_tb;

	localparam int                CYCLE_LIMIT         = 200000;
	localparam int                REPORT_LIMIT        = 10;
	localparam int                RANDOM_PHASE_ITEMS  = 560;
	localparam logic [ilid_pkg::CMD_W-1:0] CMD_FIRST_RESERVED = 3'd5;
	localparam logic [ilid_pkg::CMD_W-1:0] CMD_LAST_RESERVED  = 3'd7;
	localparam logic [ilid_pkg::CNT_W-1:0] POS_MAX            = '1;
	localparam logic signed [ilid_pkg::DATA_W-1:0] VAL_MIN    = 32'sh8000_0000;
	localparam logic signed [ilid_pkg::DATA_W-1:0] VAL_MAX    = 32'sh7fff_ffff;
	localparam logic signed [ilid_pkg::DATA_W-1:0] VAL_NONE   = -32'sd1;

	typedef struct {
		logic signed [ilid_pkg::DATA_W-1:0] read_value;
		logic                               found;
		ilid_pkg::status_t                  status;
		logic [ilid_pkg::CNT_W-1:0]         length;
	} list_result_t;

	logic                               clk;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic [ilid_pkg::CMD_W-1:0]         cmd;
	logic [ilid_pkg::CNT_W-1:0]         position;
	logic signed [ilid_pkg::DATA_W-1:0] value_in;
	logic                               out_valid;
	logic                               out_ready;
	logic signed [ilid_pkg::DATA_W-1:0] read_value;
	logic                               found;
	logic [1:0]                         status;
	logic [ilid_pkg::CNT_W-1:0]         length;

	// Local copy of the list contents
	logic signed [ilid_pkg::DATA_W-1:0] list_store [ilid_pkg::CAPACITY];
	int unsigned                        list_count;

	list_result_t expected_results[$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_left;
	int unsigned cycle_count;
	int unsigned mismatch_count;
	int unsigned results_checked;
	int unsigned commands_sent;
	int unsigned full_rejects;
	int unsigned range_rejects;
	bit          growing;

	indexed_list_insert_delete_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.position   (position),
		.value_in   (value_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.found      (found),
		.status     (status),
		.length     (length)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Drive out_ready: random stalls, or a forced hold-off while hold_left runs
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready = 1'b0;
				hold_left--;
			end else begin
				out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	task automatic note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	// Shift later entries up and place the new value; reject when full
	function automatic ilid_pkg::status_t insert_entry(input int unsigned pos,
			input logic signed [ilid_pkg::DATA_W-1:0] val);
		if (list_count >= ilid_pkg::CAPACITY)
			return ilid_pkg::ST_FULL;
		for (int unsigned i = list_count; i > pos; i--)
			list_store[i] = list_store[i-1];
		list_store[pos] = val;
		list_count++;
		return ilid_pkg::ST_DONE;
	endfunction

	// Apply one command to the local list and return the result it yields
	function automatic list_result_t apply_list_command(
			input logic [ilid_pkg::CMD_W-1:0] c,
			input logic [ilid_pkg::CNT_W-1:0] p,
			input logic signed [ilid_pkg::DATA_W-1:0] v);
		list_result_t r;
		r.read_value = VAL_NONE;
		r.found      = 1'b0;
		r.status     = ilid_pkg::ST_DONE;
		case (c)
			ilid_pkg::CMD_GET: begin
				if (p < list_count) begin
					r.read_value = list_store[p[ilid_pkg::IDX_W-1:0]];
					r.found      = 1'b1;
				end else begin
					r.status = ilid_pkg::ST_RANGE;
				end
			end
			ilid_pkg::CMD_INS_HEAD: r.status = insert_entry(0, v);
			ilid_pkg::CMD_INS_TAIL: r.status = insert_entry(list_count, v);
			ilid_pkg::CMD_INS_AT: begin
				if (p > list_count)
					r.status = ilid_pkg::ST_RANGE;
				else
					r.status = insert_entry(32'(p), v);
			end
			ilid_pkg::CMD_DEL_AT: begin
				if (p >= list_count) begin
					r.status = ilid_pkg::ST_RANGE;
				end else begin
					for (int unsigned i = 32'(p); i + 1 < list_count; i++)
						list_store[i] = list_store[i+1];
					list_count--;
				end
			end
			default: ;
		endcase
		r.length = list_count[ilid_pkg::CNT_W-1:0];
		return r;
	endfunction

	// Offer one command, wait for its transfer, then record the expected result
	task automatic send_command(input logic [ilid_pkg::CMD_W-1:0] c,
			input logic [ilid_pkg::CNT_W-1:0] p,
			input logic signed [ilid_pkg::DATA_W-1:0] v);
		list_result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd      = c;
		position = p;
		value_in = v;
		do
			@(posedge clk);
		while (!in_ready);
		r = apply_list_command(c, p, v);
		if (r.status == ilid_pkg::ST_FULL)
			full_rejects++;
		if (r.status == ilid_pkg::ST_RANGE)
			range_rejects++;
		commands_sent++;
		expected_results.push_back(r);
	endtask

	// Compare each transferred result with the oldest expectation
	always @(posedge clk) begin : check_results
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				note_failure($sformatf(
					"unexpected result: value %0d found %0b status %0d length %0d",
					read_value, found, status, length));
			end else begin
				want = expected_results.pop_front();
				if (read_value !== want.read_value || found !== want.found ||
						status !== want.status || length !== want.length)
					note_failure({
						$sformatf("result %0d: expected value %0d found %0b",
							results_checked, want.read_value, want.found),
						$sformatf(" status %0d length %0d,", want.status, want.length),
						$sformatf(" got value %0d found %0b status %0d length %0d",
							read_value, found, status, length)});
			end
		end
	end

	function automatic logic signed [ilid_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return '0;
			3:       return VAL_NONE;
			default: return $urandom;
		endcase
	endfunction

	// Pick an index: mostly valid, sometimes at the bound, sometimes anywhere
	function automatic logic [ilid_pkg::CNT_W-1:0] pick_position(input int unsigned upper);
		int unsigned sel;
		sel = $urandom_range(0, 99);
		if (sel < 80 && upper > 0)
			return ilid_pkg::CNT_W'($urandom_range(0, upper - 1));
		else if (sel < 90)
			return upper[ilid_pkg::CNT_W-1:0];
		else
			return ilid_pkg::CNT_W'($urandom_range(0, POS_MAX));
	endfunction

	task automatic test_empty_list();
		send_command(ilid_pkg::CMD_GET, 0, VAL_MAX);
		send_command(ilid_pkg::CMD_GET, POS_MAX, VAL_MIN);
		send_command(ilid_pkg::CMD_DEL_AT, 0, '0);
		send_command(ilid_pkg::CMD_INS_AT, 1, 32'sd5);
		for (int k = CMD_FIRST_RESERVED; k <= CMD_LAST_RESERVED; k++)
			send_command(k[ilid_pkg::CMD_W-1:0],
				ilid_pkg::CNT_W'($urandom_range(0, POS_MAX)), $urandom);
	endtask

	task automatic test_basic_edits();
		send_command(ilid_pkg::CMD_INS_AT, 0, 32'sh1234_5678);
		send_command(ilid_pkg::CMD_INS_HEAD, POS_MAX, VAL_MIN);
		send_command(ilid_pkg::CMD_INS_TAIL, 0, VAL_MAX);
		// insert at the current length appends
		send_command(ilid_pkg::CMD_INS_AT, 3, '0);
		send_command(ilid_pkg::CMD_INS_AT, 1, VAL_NONE);
		for (int i = 0; i <= 5; i++)
			send_command(ilid_pkg::CMD_GET, ilid_pkg::CNT_W'(i), '0);
		send_command(ilid_pkg::CMD_DEL_AT, 2, '0);
		send_command(ilid_pkg::CMD_DEL_AT, 3, '0);
		// the slot just vacated at the tail must not read back
		send_command(ilid_pkg::CMD_GET, 3, '0);
		send_command(ilid_pkg::CMD_DEL_AT, 0, '0);
		send_command(ilid_pkg::CMD_GET, 0, '0);
	endtask

	task automatic test_full_list();
		while (list_count < ilid_pkg::CAPACITY)
			send_command(ilid_pkg::CMD_INS_TAIL,
				ilid_pkg::CNT_W'($urandom_range(0, POS_MAX)), pick_value());
		send_command(ilid_pkg::CMD_INS_HEAD, 0, 32'sd1);
		send_command(ilid_pkg::CMD_INS_TAIL, 0, 32'sd2);
		send_command(ilid_pkg::CMD_INS_AT, 0, 32'sd3);
		send_command(ilid_pkg::CMD_INS_AT, ilid_pkg::CNT_W'(ilid_pkg::CAPACITY), 32'sd4);
		// out of range wins over full
		send_command(ilid_pkg::CMD_INS_AT, ilid_pkg::CNT_W'(ilid_pkg::CAPACITY + 1),
			32'sd5);
		send_command(ilid_pkg::CMD_GET, ilid_pkg::CNT_W'(ilid_pkg::CAPACITY - 1), '0);
		send_command(ilid_pkg::CMD_GET, ilid_pkg::CNT_W'(ilid_pkg::CAPACITY), '0);
		send_command(ilid_pkg::CMD_DEL_AT, ilid_pkg::CNT_W'(ilid_pkg::CAPACITY), '0);
		while (list_count > 0)
			send_command(ilid_pkg::CMD_DEL_AT,
				ilid_pkg::CNT_W'($urandom_range(0, list_count - 1)), '0);
		send_command(ilid_pkg::CMD_DEL_AT, 0, '0);
	endtask

	// Stall the output for a long stretch while commands keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		hold_left     = 300;
		repeat (40)
			send_command(ilid_pkg::CMD_INS_AT, pick_position(list_count + 1), pick_value());
	endtask

	// Random traffic that swings the list between empty and full
	task automatic test_random_traffic(input int unsigned n_items);
		int unsigned                sel;
		logic [ilid_pkg::CMD_W-1:0] c;
		logic [ilid_pkg::CNT_W-1:0] p;
		repeat (n_items) begin
			if (list_count == ilid_pkg::CAPACITY && $urandom_range(0, 7) == 0)
				growing = 1'b0;
			if (list_count == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 5) begin
				c = ilid_pkg::CMD_W'($urandom_range(CMD_FIRST_RESERVED, CMD_LAST_RESERVED));
				p = ilid_pkg::CNT_W'($urandom_range(0, POS_MAX));
			end else if (sel < 30) begin
				c = ilid_pkg::CMD_GET;
				p = pick_position(list_count);
			end else if (sel < (growing ? 45 : 85)) begin
				c = ilid_pkg::CMD_DEL_AT;
				p = pick_position(list_count);
			end else begin
				case ($urandom_range(0, 2))
					0:       c = ilid_pkg::CMD_INS_HEAD;
					1:       c = ilid_pkg::CMD_INS_TAIL;
					default: c = ilid_pkg::CMD_INS_AT;
				endcase
				p = (c == ilid_pkg::CMD_INS_AT) ? pick_position(list_count + 1)
					: ilid_pkg::CNT_W'($urandom_range(0, POS_MAX));
			end
			send_command(c, p, pick_value());
		end
	endtask

	// Run reset, then each test in turn
	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		cmd            = ilid_pkg::CMD_GET;
		position       = '0;
		value_in       = '0;
		send_idle_pct  = 29;
		recv_stall_pct = 55;
		hold_left      = 0;
		cycle_count    = 0;
		mismatch_count = 0;
		results_checked = 0;
		commands_sent  = 0;
		full_rejects   = 0;
		range_rejects  = 0;
		growing        = 1'b1;
		list_count     = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_basic_edits();
		test_full_list();
		test_random_traffic(RANDOM_PHASE_ITEMS);
		send_idle_pct  = 55;
		recv_stall_pct = 29;
		test_random_traffic(RANDOM_PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		test_random_traffic(RANDOM_PHASE_ITEMS);
		test_backpressure();

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_results.size() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (mismatch_count > REPORT_LIMIT)
			$display("%0d further mismatches not shown", mismatch_count - REPORT_LIMIT);
		$display("Sent %0d commands and checked %0d results in %0d cycles.",
			commands_sent, results_checked, cycle_count);
		$display("Inserts refused on a full list: %0d, indexes out of range: %0d.",
			full_rejects, range_rejects);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/ilid_pkg.sv
src/ilid_cell.sv
src/ilid_ctrl.sv
src/indexed_list_insert_delete_unit.sv
src/ilid_checker.sv
test/indexed_list_insert_delete_unit_tb.sv
